// ----- hdl/mptq_pkg.sv -----
// Shared types and constants for the multi-level priority task queue.
// No dependencies; compiled first.
package mptq_pkg;

	localparam int LEVELS          = 4;
	localparam int TASK_BITS       = 32;
	localparam int LEVEL_DEPTH_DEF = 16;
	localparam int SIDE_DEPTH_DEF  = 16;
	localparam int OP_BITS         = 3;
	localparam int LVL_BITS        = 2;
	localparam int SRC_BITS        = 3;
	localparam int TOTAL_BITS      = 7;
	localparam int CNT_OUT_BITS    = 5;
	localparam int CTR_BITS        = 32;

	typedef enum logic [OP_BITS-1:0] {
		OP_PUSH      = 3'd0,
		OP_SIDE_PUSH = 3'd1,
		OP_POP       = 3'd2,
		OP_STEAL     = 3'd3,
		OP_CLEAR     = 3'd4,
		OP_QUERY     = 3'd5
	} op_t;

	localparam logic [SRC_BITS-1:0] SRC_SIDE = 3'd4;

	typedef struct packed {
		logic [OP_BITS-1:0]   op;
		logic [LVL_BITS-1:0]  level;
		logic [TASK_BITS-1:0] task_in;
	} req_t;

	typedef struct packed {
		logic                    ok;
		logic [TASK_BITS-1:0]    task_out;
		logic [SRC_BITS-1:0]     source;
		logic                    all_empty;
		logic [TOTAL_BITS-1:0]   local_total;
		logic [CNT_OUT_BITS-1:0] level_count;
		logic [CTR_BITS-1:0]     push_total;
		logic [CTR_BITS-1:0]     pop_total;
		logic [CTR_BITS-1:0]     steal_total;
	} rsp_t;

	// Result of one request before the task word is read out of storage.
	typedef struct packed {
		logic                    ok;
		logic [SRC_BITS-1:0]     source;
		logic                    all_empty;
		logic [TOTAL_BITS-1:0]   local_total;
		logic [CNT_OUT_BITS-1:0] level_count;
		logic [CTR_BITS-1:0]     push_total;
		logic [CTR_BITS-1:0]     pop_total;
		logic [CTR_BITS-1:0]     steal_total;
	} stat_t;

endpackage

// ----- hdl/mptq_chan.sv -----
// Valid/ready channel carrying one payload of type T.
// No dependencies.
interface mptq_chan #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/mptq_ram.sv -----
// Simple dual-port task store: one write port, one registered read port.
// No dependencies.
module mptq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/mptq_ctrl.sv -----
// Queue control: pointers, fill counts, service selection and counters.
// Depends on mptq_pkg; drives the two mptq_ram instances in the top level.
module mptq_ctrl import mptq_pkg::*; #(
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
	parameter int SIDE_DEPTH  = SIDE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  exec,
	input  req_t                                  req,
	output logic                                  lvl_we,
	output logic [$clog2(LEVELS*LEVEL_DEPTH)-1:0] lvl_waddr,
	output logic                                  lvl_re,
	output logic [$clog2(LEVELS*LEVEL_DEPTH)-1:0] lvl_raddr,
	output logic                                  side_we,
	output logic [$clog2(SIDE_DEPTH)-1:0]         side_waddr,
	output logic                                  side_re,
	output logic [$clog2(SIDE_DEPTH)-1:0]         side_raddr,
	output stat_t                                 stat
);

	localparam int LPW  = $clog2(LEVEL_DEPTH);
	localparam int SPW  = $clog2(SIDE_DEPTH);
	localparam int LCW  = $clog2(LEVEL_DEPTH + 1);
	localparam int SCW  = $clog2(SIDE_DEPTH + 1);
	localparam int LAW  = $clog2(LEVELS * LEVEL_DEPTH);
	localparam int TW   = $clog2(LEVELS * LEVEL_DEPTH + 1);
	localparam int LSW  = $clog2(LEVELS);

	logic [LPW-1:0] head_q [LEVELS];
	logic [LPW-1:0] head_d [LEVELS];
	logic [LPW-1:0] tail_q [LEVELS];
	logic [LPW-1:0] tail_d [LEVELS];
	logic [LCW-1:0] cnt_q  [LEVELS];
	logic [LCW-1:0] cnt_d  [LEVELS];
	logic [SPW-1:0] side_head_q, side_head_d;
	logic [SPW-1:0] side_tail_q, side_tail_d;
	logic [SCW-1:0] side_cnt_q, side_cnt_d;
	logic [CTR_BITS-1:0] push_q, push_d;
	logic [CTR_BITS-1:0] pop_q, pop_d;
	logic [CTR_BITS-1:0] steal_q, steal_d;

	logic [LSW-1:0]      lv_idx;
	logic [LSW-1:0]      pop_idx;
	logic [LSW-1:0]      steal_idx;
	logic [LSW-1:0]      take_idx;
	logic                lvl_any;
	logic                lvl_over;
	logic                ok;
	logic [SRC_BITS-1:0] src;
	logic [TW-1:0]       total;

	function automatic logic [LPW-1:0] lnext(input logic [LPW-1:0] p);
		return (p == LPW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [SPW-1:0] snext(input logic [SPW-1:0] p);
		return (p == SPW'(SIDE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign lv_idx = LSW'(req.level);

	// Pop serves the highest non-empty level, steal the lowest.
	always_comb begin
		pop_idx   = '0;
		steal_idx = '0;
		lvl_any   = 1'b0;
		lvl_over  = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (cnt_q[i] != '0) begin
				pop_idx = LSW'(i);
				lvl_any = 1'b1;
			end
			if (cnt_q[i] > LCW'(LEVEL_DEPTH)) begin
				lvl_over = 1'b1;
			end
		end
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				steal_idx = LSW'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < LEVELS; i++) begin
			head_d[i] = head_q[i];
			tail_d[i] = tail_q[i];
			cnt_d[i]  = cnt_q[i];
		end
		side_head_d = side_head_q;
		side_tail_d = side_tail_q;
		side_cnt_d  = side_cnt_q;
		push_d      = push_q;
		pop_d       = pop_q;
		steal_d     = steal_q;
		ok          = 1'b0;
		src         = '0;
		take_idx    = pop_idx;
		lvl_we      = 1'b0;
		lvl_re      = 1'b0;
		side_we     = 1'b0;
		side_re     = 1'b0;
		if (exec) begin
			unique case (req.op)
				OP_PUSH: begin
					src = SRC_BITS'(req.level);
					if (cnt_q[lv_idx] != LCW'(LEVEL_DEPTH)) begin
						lvl_we         = 1'b1;
						tail_d[lv_idx] = lnext(tail_q[lv_idx]);
						cnt_d[lv_idx]  = cnt_q[lv_idx] + 1'b1;
						push_d         = push_q + 1'b1;
						ok             = 1'b1;
					end
				end
				OP_SIDE_PUSH: begin
					src = SRC_SIDE;
					if (side_cnt_q != SCW'(SIDE_DEPTH)) begin
						side_we     = 1'b1;
						side_tail_d = snext(side_tail_q);
						side_cnt_d  = side_cnt_q + 1'b1;
						push_d      = push_q + 1'b1;
						ok          = 1'b1;
					end
				end
				OP_POP: begin
					if (lvl_any) begin
						take_idx          = pop_idx;
						lvl_re            = 1'b1;
						head_d[pop_idx]   = lnext(head_q[pop_idx]);
						cnt_d[pop_idx]    = cnt_q[pop_idx] - 1'b1;
						src               = SRC_BITS'(pop_idx);
						pop_d             = pop_q + 1'b1;
						ok                = 1'b1;
					end else if (side_cnt_q != '0) begin
						side_re     = 1'b1;
						side_head_d = snext(side_head_q);
						side_cnt_d  = side_cnt_q - 1'b1;
						src         = SRC_SIDE;
						pop_d       = pop_q + 1'b1;
						ok          = 1'b1;
					end
				end
				OP_STEAL: begin
					if (side_cnt_q != '0) begin
						side_re     = 1'b1;
						side_head_d = snext(side_head_q);
						side_cnt_d  = side_cnt_q - 1'b1;
						src         = SRC_SIDE;
						steal_d     = steal_q + 1'b1;
						ok          = 1'b1;
					end else if (lvl_any) begin
						take_idx          = steal_idx;
						lvl_re            = 1'b1;
						head_d[steal_idx] = lnext(head_q[steal_idx]);
						cnt_d[steal_idx]  = cnt_q[steal_idx] - 1'b1;
						src               = SRC_BITS'(steal_idx);
						steal_d           = steal_q + 1'b1;
						ok                = 1'b1;
					end
				end
				OP_CLEAR: begin
					for (int i = 0; i < LEVELS; i++) begin
						head_d[i] = '0;
						tail_d[i] = '0;
						cnt_d[i]  = '0;
					end
					side_head_d = '0;
					side_tail_d = '0;
					side_cnt_d  = '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign lvl_waddr  = LAW'(lv_idx) * LAW'(LEVEL_DEPTH) + LAW'(tail_q[lv_idx]);
	assign lvl_raddr  = LAW'(take_idx) * LAW'(LEVEL_DEPTH) + LAW'(head_q[take_idx]);
	assign side_waddr = side_tail_q;
	assign side_raddr = side_head_q;

	always_comb begin
		total = '0;
		for (int i = 0; i < LEVELS; i++) begin
			total = total + TW'(cnt_d[i]);
		end
	end

	always_comb begin
		stat.ok          = ok;
		stat.source      = src;
		stat.all_empty   = (total == '0) && (side_cnt_d == '0);
		stat.local_total = TOTAL_BITS'(total);
		stat.level_count = CNT_OUT_BITS'(cnt_d[lv_idx]);
		stat.push_total  = push_d;
		stat.pop_total   = pop_d;
		stat.steal_total = steal_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			side_head_q <= '0;
			side_tail_q <= '0;
			side_cnt_q  <= '0;
			push_q      <= '0;
			pop_q       <= '0;
			steal_q     <= '0;
		end else begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= head_d[i];
				tail_q[i] <= tail_d[i];
				cnt_q[i]  <= cnt_d[i];
			end
			side_head_q <= side_head_d;
			side_tail_q <= side_tail_d;
			side_cnt_q  <= side_cnt_d;
			push_q      <= push_d;
			pop_q       <= pop_d;
			steal_q     <= steal_d;
		end
	end

	a_lvl_bound: assert property (@(posedge clk) disable iff (!arst_n) !lvl_over)
		else $error("level fill count above depth");

	a_side_bound: assert property (@(posedge clk) disable iff (!arst_n)
		side_cnt_q <= SCW'(SIDE_DEPTH))
		else $error("side fill count above depth");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		exec && req.op == OP_CLEAR |=> !lvl_any && side_cnt_q == '0)
		else $error("queues not empty after clear");

	a_ctr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!exec |=> $stable(push_q) && $stable(pop_q) && $stable(steal_q))
		else $error("counter moved without a request");

	a_pop_order: assert property (@(posedge clk) disable iff (!arst_n)
		exec && req.op == OP_POP && lvl_any |-> !side_re && lvl_re)
		else $error("pop took side queue while a level held work");

endmodule

// ----- hdl/multi_priority_task_queue.sv -----
// Top level of the multi-level priority task queue.
// Depends on mptq_pkg, mptq_chan, mptq_ram and mptq_ctrl.
//
// Usage:
//   req  - request channel (valid/ready, payload req_t): op, level, task_in.
//          Ops: push to a priority level, side push, pop, steal, clear, query.
//   rsp  - response channel (valid/ready, payload rsp_t): exactly one response
//          per request, in request order.
//   Pop serves the highest non-empty level, then the side queue; steal serves
//   the side queue, then levels from lowest up. Each response also carries
//   the all-empty flag, the sum of level fill counts, the fill count of the
//   requested level and wrapping push/pop/steal counters.
//
// Timing:
//   Two register stages: the request register (s1) and the response register
//   (s2). A request in s1 executes when s2 can take it; its response is then
//   registered in s2. One request per cycle sustained while rsp.ready stays high;
//   all queue updates and the service pick finish in the cycle a request
//   executes from s1, and the task word read comes from the registered read port of the task stores.
//
// Reset clears all pointers, fill counts and counters; task stores are not
// cleared and need no sweep. When the receiver stalls, s2 holds its response
// and s1 can still take one more request; after that req.ready drops.
module multi_priority_task_queue import mptq_pkg::*; #(
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
	parameter int SIDE_DEPTH  = SIDE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	mptq_chan.sink   req,
	mptq_chan.source rsp
);

	localparam int LAW = $clog2(LEVELS * LEVEL_DEPTH);
	localparam int SAW = $clog2(SIDE_DEPTH);

	logic  s1_valid_q;
	req_t  req_s1;
	logic  s2_valid_q;
	stat_t stat_s2;
	logic  s2_took_q;

	logic  adv2;
	logic  exec;
	logic  took;
	stat_t stat;

	logic                 lvl_we, lvl_re, side_we, side_re;
	logic [LAW-1:0]       lvl_waddr, lvl_raddr;
	logic [SAW-1:0]       side_waddr, side_raddr;
	logic [TASK_BITS-1:0] lvl_rdata, side_rdata;

	// s2 moves when empty or drained; s1 executes only when s2 can take it.
	assign adv2      = !s2_valid_q || rsp.ready;
	assign exec      = s1_valid_q && adv2;
	assign req.ready = !s1_valid_q || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				s1_valid_q <= req.valid;
			end
			if (adv2) begin
				s2_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
		if (exec) begin
			stat_s2 <= stat;
		end
	end

	mptq_ctrl #(
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.SIDE_DEPTH  (SIDE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.exec       (exec),
		.req        (req_s1),
		.lvl_we     (lvl_we),
		.lvl_waddr  (lvl_waddr),
		.lvl_re     (lvl_re),
		.lvl_raddr  (lvl_raddr),
		.side_we    (side_we),
		.side_waddr (side_waddr),
		.side_re    (side_re),
		.side_raddr (side_raddr),
		.stat       (stat)
	);

	// Priority levels share one store, each level owning a LEVEL_DEPTH slice.
	mptq_ram #(
		.DEPTH (LEVELS * LEVEL_DEPTH),
		.WIDTH (TASK_BITS)
	) u_lvl_ram (
		.clk   (clk),
		.we    (lvl_we),
		.waddr (lvl_waddr),
		.wdata (req_s1.task_in),
		.re    (lvl_re),
		.raddr (lvl_raddr),
		.rdata (lvl_rdata)
	);

	mptq_ram #(
		.DEPTH (SIDE_DEPTH),
		.WIDTH (TASK_BITS)
	) u_side_ram (
		.clk   (clk),
		.we    (side_we),
		.waddr (side_waddr),
		.wdata (req_s1.task_in),
		.re    (side_re),
		.raddr (side_raddr),
		.rdata (side_rdata)
	);

	// Read data registers only load on a take, so they hold through a stall.
	// A successful push also reports ok, but its source then names the queue
	// written, so the task word is shown only for pop and steal.
	always_ff @(posedge clk) begin
		if (exec) begin
			s2_took_q <= (req_s1.op == OP_POP) || (req_s1.op == OP_STEAL);
		end
	end

	assign took = stat_s2.ok && s2_took_q;

	assign rsp.valid = s2_valid_q;
	assign rsp.data  = '{
		ok:          stat_s2.ok,
		task_out:    !took ? '0 : (stat_s2.source == SRC_SIDE) ? side_rdata : lvl_rdata,
		source:      stat_s2.source,
		all_empty:   stat_s2.all_empty,
		local_total: stat_s2.local_total,
		level_count: stat_s2.level_count,
		push_total:  stat_s2.push_total,
		pop_total:   stat_s2.pop_total,
		steal_total: stat_s2.steal_total
	};

	a_one_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> s2_valid_q)
		else $error("executed request lost its response slot");

	a_no_skip: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !adv2 |=> s1_valid_q && $stable(req_s1))
		else $error("pending request dropped during stall");

	a_took_ok: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && took |-> stat_s2.ok)
		else $error("task shown without a successful take");

endmodule
